// ===== rtl/lrc_pkg.sv =====
package lrc_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_SET  = 2'd2
	} mode_t;

	localparam int RingWidth    = 10;
	localparam int CountWidth   = 16;
	localparam int PeriodWidth  = 7;
	localparam int PinWidth     = 6;

	localparam logic [CountWidth-1:0]  LongPressReset = 16'd3000;
	localparam logic [CountWidth-1:0]  BlinkReset     = 16'd250;
	localparam logic [CountWidth-1:0]  CountMax       = 16'hFFFF;
	localparam logic [RingWidth-1:0]   RingFirst      = 10'b0000000001;
	localparam logic [RingWidth:0]     RingLast       = 11'b01000000000;
	localparam logic [PeriodWidth-1:0] PeriodStep     = 7'd10;
	localparam logic [PeriodWidth-1:0] PeriodMax      = 7'd100;
	localparam logic [PeriodWidth-1:0] PeriodReset    = 7'd50;

	localparam logic [2:0] RegLongPress = 3'd0;
	localparam logic [2:0] RegBlink     = 3'd4;

	function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] c);
		sat_inc = (c == CountMax) ? CountMax : c + 16'd1;
	endfunction

	// Bargraph length is 11 - period/10, clamped to 0..10; quotient by threshold count.
	function automatic logic [RingWidth-1:0] bargraph(input logic [PeriodWidth-1:0] period);
		logic [3:0] q;
		logic [3:0] n;
		logic [RingWidth-1:0] bar;
		q = 4'd0;
		for (int k = 1; k <= 12; k++) begin
			if ({1'b0, period} >= 8'(10 * k))
				q = q + 4'd1;
		end
		if (q >= 4'd11)
			n = 4'd0;
		else if (q == 4'd0)
			n = 4'd10;
		else
			n = 4'd11 - q;
		for (int i = 0; i < RingWidth; i++)
			bar[i] = (4'(i) < n);
		bargraph = bar;
	endfunction

endpackage

// ===== rtl/led_ring_chaser_mode_control_core.sv =====
// Ten-LED ring controller. Each input transaction is a 1 ms tick (s_tuser = 0) or a
// button edge (s_tuser = 1, s_tdata[0] = pressed level); every input transaction yields
// one output transaction carrying the display pattern, the two pin-mapped port
// words and the current mode. An item is registered on entry and fully processed from s1
// into the output register, so one item can be accepted every cycle while the output
// is not held; the only thing that slows intake is m_tready held low.
// Registers long_press_ticks (0x0) and blink_ticks (0x4) sit on the APB port and
// should be written only while no transaction is in flight.
module led_ring_chaser_mode_control_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] button_pressed, [7:1] zero
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [9:0] display, [15:10] porta_pins, [21:16] portc_pins,
	                               // [23:22] mode
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RW = lrc_pkg::RingWidth;
	localparam int CW = lrc_pkg::CountWidth;
	localparam int PW = lrc_pkg::PeriodWidth;

	logic [CW-1:0] long_press_q;
	logic [CW-1:0] blink_ticks_q;

	logic          valid_s1;
	logic          cmd_s1;
	logic          pressed_s1;
	logic          advance;

	lrc_pkg::mode_t mode_q, mode_d;
	logic [RW-1:0] ring_q, ring_d;
	logic [PW-1:0] period_q, period_d;
	logic [CW-1:0] step_q, step_d;
	logic [CW-1:0] blink_q, blink_d;
	logic [CW-1:0] hold_q, hold_d;
	logic [RW-1:0] latch_q, latch_d;
	logic [RW:0]   ring_next;

	logic          out_valid_q;
	logic [23:0]   out_data_q;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q  <= lrc_pkg::LongPressReset;
			blink_ticks_q <= lrc_pkg::BlinkReset;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == lrc_pkg::RegBlink[2])
				blink_ticks_q <= pwdata[CW-1:0];
			else
				long_press_q <= pwdata[CW-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == lrc_pkg::RegBlink[2])
			prdata = {16'd0, blink_ticks_q};
		else
			prdata = {16'd0, long_press_q};
	end

	// Handshake: s1 drains whenever the output register is free or being taken
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1     <= s_tuser;
			pressed_s1 <= s_tdata[0];
		end
	end

	// Item processing
	always_comb begin
		mode_d   = mode_q;
		ring_d   = ring_q;
		period_d = period_q;
		step_d   = step_q;
		blink_d  = blink_q;
		hold_d   = hold_q;
		latch_d  = latch_q;

		if (!cmd_s1) begin
			step_d  = lrc_pkg::sat_inc(step_q);
			blink_d = lrc_pkg::sat_inc(blink_q);
			hold_d  = lrc_pkg::sat_inc(hold_q);
		end else if (pressed_s1) begin
			hold_d = '0;
		end else if (hold_q < long_press_q) begin
			unique case (mode_q)
				lrc_pkg::MODE_IDLE: begin
					step_d = '0;
					mode_d = lrc_pkg::MODE_RUN;
				end
				lrc_pkg::MODE_RUN: begin
					blink_d = '0;
					mode_d  = lrc_pkg::MODE_IDLE;
				end
				lrc_pkg::MODE_SET: begin
					// wrap from the shortest period back to the longest
					if (period_q < lrc_pkg::PeriodStep + lrc_pkg::PeriodStep)
						period_d = lrc_pkg::PeriodMax;
					else
						period_d = period_q - lrc_pkg::PeriodStep;
				end
				default: ;
			endcase
		end else begin
			unique case (mode_q)
				lrc_pkg::MODE_IDLE,
				lrc_pkg::MODE_RUN: mode_d = lrc_pkg::MODE_SET;
				lrc_pkg::MODE_SET: begin
					step_d = '0;
					mode_d = lrc_pkg::MODE_RUN;
				end
				default: ;
			endcase
		end

		ring_next = {ring_d, 1'b0};
		if (ring_next > lrc_pkg::RingLast || ring_next == '0)
			ring_next = {1'b0, lrc_pkg::RingFirst};

		unique case (mode_d)
			lrc_pkg::MODE_IDLE: begin
				if (blink_d > blink_ticks_q) begin
					latch_d = latch_d ^ ring_d;
					blink_d = '0;
				end
			end
			lrc_pkg::MODE_RUN: begin
				if (step_d > CW'(period_d)) begin
					ring_d  = ring_next[RW-1:0];
					latch_d = ring_next[RW-1:0];
					step_d  = '0;
				end
			end
			lrc_pkg::MODE_SET: latch_d = lrc_pkg::bargraph(period_d);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= lrc_pkg::MODE_IDLE;
			ring_q   <= lrc_pkg::RingFirst;
			period_q <= lrc_pkg::PeriodReset;
			step_q   <= '0;
			blink_q  <= '0;
			hold_q   <= '0;
			latch_q  <= '0;
		end else if (valid_s1 && advance) begin
			mode_q   <= mode_d;
			ring_q   <= ring_d;
			period_q <= period_d;
			step_q   <= step_d;
			blink_q  <= blink_d;
			hold_q   <= hold_d;
			latch_q  <= latch_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_data_q <= {
				mode_d,
				latch_d[7:5], 1'b0, latch_d[4:3],
				latch_d[9:8], 1'b0, latch_d[2:0],
				latch_d
			};
		end
	end

endmodule
